[hw/rtl/text_console_scroll_writer_assert.svh]
// Assertion macros for the text console block.
`ifndef TEXT_CONSOLE_SCROLL_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_SCROLL_WRITER_ASSERT_SVH

// Check on every clock edge once reset is released.
`define TCSW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tcsw assertion failed");

// Check on every clock edge, reset included.
`define TCSW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tcsw assertion failed");

`endif

[hw/rtl/tcsw_pkg.sv]
`timescale 1ns / 1ps

package tcsw_pkg;

  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = COLUMNS * ROWS;

  localparam int unsigned OpW    = 2;
  localparam int unsigned CharW  = 8;
  localparam int unsigned RowW   = 5;
  localparam int unsigned ColW   = 7;
  localparam int unsigned CellAw = $clog2(CELLS);

  localparam logic [CharW-1:0] NewlineCode = 8'd10;
  localparam logic [CharW-1:0] SpaceCode   = 8'd32;
  localparam logic [CharW-1:0] ResetColor  = 8'd15;

  typedef enum logic [OpW-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // One screen cell: attribute in the upper byte, character in the lower.
  typedef struct packed {
    logic [CharW-1:0] color;
    logic [CharW-1:0] chr;
  } cell_t;

  typedef struct packed {
    logic              we;
    logic [CellAw-1:0] addr;
    cell_t             data;
  } ram_wr_t;

  typedef struct packed {
    logic              re;
    logic [CellAw-1:0] addr;
  } ram_rd_t;

endpackage

[hw/rtl/tcsw_req_if.sv]
`timescale 1ns / 1ps

interface tcsw_req_if;
  logic                         valid;
  logic                         ready;
  logic [tcsw_pkg::OpW-1:0]     op;
  logic [tcsw_pkg::CharW-1:0]   char_code;
  logic [tcsw_pkg::RowW-1:0]    read_row;
  logic [tcsw_pkg::ColW-1:0]    read_col;

  modport source (output valid, op, char_code, read_row, read_col, input ready);
  modport sink   (input valid, op, char_code, read_row, read_col, output ready);
endinterface

[hw/rtl/tcsw_rsp_if.sv]
`timescale 1ns / 1ps

interface tcsw_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [tcsw_pkg::RowW-1:0]    cursor_row_out;
  logic [tcsw_pkg::ColW-1:0]    cursor_col_out;
  logic [tcsw_pkg::CharW-1:0]   cell_char;
  logic [tcsw_pkg::CharW-1:0]   cell_color;

  modport source (output valid, cursor_row_out, cursor_col_out, cell_char, cell_color,
                  input ready);
  modport sink   (input valid, cursor_row_out, cursor_col_out, cell_char, cell_color,
                  output ready);
endinterface

[hw/rtl/tcsw_cfg_if.sv]
`timescale 1ns / 1ps

interface tcsw_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tcsw_pkg::CharW-1:0]   text_color;

  modport source (output valid, text_color, input ready);
  modport sink   (input valid, text_color, output ready);
endinterface

[hw/rtl/text_console_scroll_writer.sv]
// Text console engine: an 80 x 25 screen of character/attribute cells and a cursor.
// Channels: req_i takes one request (op, char_code, read_row, read_col); rsp_o returns
// exactly one result per request (cursor after the op, plus the cell for a read);
// cfg_i writes the text_color attribute and is always ready. Write it only while idle.
// What each request does:
//   put of a plain character ........ one memory write
//   put that wraps, newline mid-screen  cursor moves down a row, no scroll
//   read of a cell .................. one registered memory read, none off screen
//   newline or wrap on the bottom row  the scroll copies
//     every row up through the single read and write port, then blanks the bottom row
//   clear ........................... fills every cell with a space, one cell per cycle
// One request is in flight at a time; req_i.ready is high only when the engine is idle,
// so a new request is not taken until the last one has reached its result.
// The result sits in an output register: the next request is taken while it still
// waits, and the engine holds in its final step only if that register is still full.
// Reset: cursor goes to 0,0 and text_color to 15, then a clearing pass writes zero to
// all CELLS = 2000 cells, one per cycle; requests are held off until that pass ends.
`timescale 1ns / 1ps
`include "text_console_scroll_writer_assert.svh"

module text_console_scroll_writer (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcsw_req_if.sink   req_i,
  tcsw_rsp_if.source rsp_o,
  tcsw_cfg_if.sink   cfg_i
);

  localparam int unsigned CellAw = tcsw_pkg::CellAw;
  localparam int unsigned RowW   = tcsw_pkg::RowW;
  localparam int unsigned ColW   = tcsw_pkg::ColW;
  localparam int unsigned CharW  = tcsw_pkg::CharW;

  // One-hot sequencer states.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_WRITE  = 6'b000010,
    S_READ   = 6'b000100,
    S_SCROLL = 6'b001000,
    S_FILL   = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  function automatic logic [CellAw-1:0] cell_addr(input logic [RowW-1:0] row,
                                                  input logic [ColW-1:0] col);
    return CellAw'(row) * CellAw'(tcsw_pkg::COLUMNS) + CellAw'(col);
  endfunction

  state_e                state_q, state_d;
  logic [CellAw-1:0]     cnt_q, cnt_d;
  logic [RowW-1:0]       row_q, row_d;
  logic [ColW-1:0]       col_q, col_d;
  logic [CharW-1:0]      color_q;
  logic                  fill_zero_q, fill_zero_d;
  logic                  pend_q, pend_d;
  logic [CharW-1:0]      pend_char_q, pend_char_d;
  tcsw_pkg::cell_t       cell_q, cell_d;

  logic                  rsp_valid_q;
  logic [RowW-1:0]       rsp_row_q;
  logic [ColW-1:0]       rsp_col_q;
  tcsw_pkg::cell_t       rsp_cell_q;
  logic                  rsp_load;

  tcsw_pkg::ram_wr_t     ram_wr;
  tcsw_pkg::ram_rd_t     ram_rd;
  tcsw_pkg::cell_t       ram_rdata;

  logic                  req_fire;
  logic                  row_last;
  logic                  col_full;
  logic                  read_in_range;

  tcsw_screen_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (ram_wr),
    .rd_i    (ram_rd),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  assign row_last      = (32'(row_q) == tcsw_pkg::ROWS - 1);
  assign col_full      = (32'(col_q) >= tcsw_pkg::COLUMNS);
  assign read_in_range = (32'(req_i.read_row) < tcsw_pkg::ROWS) &&
                         (32'(req_i.read_col) < tcsw_pkg::COLUMNS);

  // Sequencer. Reads and writes never touch the same cell in one cycle: a scroll reads
  // COLUMNS + 1 cells ahead of its write, and every other op does one access per step.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    row_d       = row_q;
    col_d       = col_q;
    fill_zero_d = fill_zero_q;
    pend_d      = pend_q;
    pend_char_d = pend_char_q;
    cell_d      = cell_q;
    rsp_load    = 1'b0;
    ram_wr      = '0;
    ram_rd      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          cell_d = '0;
          unique case (tcsw_pkg::op_e'(req_i.op))
            tcsw_pkg::OP_PUT: begin
              if (req_i.char_code == tcsw_pkg::NewlineCode) begin
                // Newline: column 0 of the next row, scroll from the bottom row.
                col_d = '0;
                if (!row_last) begin
                  row_d   = row_q + RowW'(1);
                  state_d = S_DONE;
                end else begin
                  pend_d  = 1'b0;
                  cnt_d   = '0;
                  state_d = S_SCROLL;
                end
              end else if (col_full) begin
                // Full row: wrap first, then write the character at column 0.
                col_d       = '0;
                pend_char_d = req_i.char_code;
                if (!row_last) begin
                  row_d   = row_q + RowW'(1);
                  state_d = S_WRITE;
                end else begin
                  pend_d  = 1'b1;
                  cnt_d   = '0;
                  state_d = S_SCROLL;
                end
              end else begin
                ram_wr.we   = 1'b1;
                ram_wr.addr = cell_addr(row_q, col_q);
                ram_wr.data = '{color: color_q, chr: req_i.char_code};
                col_d       = col_q + ColW'(1);
                state_d     = S_DONE;
              end
            end
            tcsw_pkg::OP_CLEAR: begin
              cnt_d       = '0;
              fill_zero_d = 1'b0;
              pend_d      = 1'b0;
              state_d     = S_FILL;
            end
            tcsw_pkg::OP_READ: begin
              if (read_in_range) begin
                ram_rd.re   = 1'b1;
                ram_rd.addr = cell_addr(req_i.read_row, req_i.read_col);
                state_d     = S_READ;
              end else begin
                state_d = S_DONE;
              end
            end
            tcsw_pkg::OP_NONE: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_WRITE: begin
        ram_wr.we   = 1'b1;
        ram_wr.addr = cell_addr(row_q, col_q);
        ram_wr.data = '{color: color_q, chr: pend_char_q};
        col_d       = col_q + ColW'(1);
        state_d     = S_DONE;
      end

      S_READ: begin
        cell_d  = ram_rdata;
        state_d = S_DONE;
      end

      S_SCROLL: begin
        // Read cell cnt+COLUMNS, write the cell read last cycle one row up at cnt-1.
        if (32'(cnt_q) < tcsw_pkg::CELLS - tcsw_pkg::COLUMNS) begin
          ram_rd.re   = 1'b1;
          ram_rd.addr = cnt_q + CellAw'(tcsw_pkg::COLUMNS);
        end
        if (cnt_q != '0) begin
          ram_wr.we   = 1'b1;
          ram_wr.addr = cnt_q - CellAw'(1);
          ram_wr.data = ram_rdata;
        end
        if (32'(cnt_q) == tcsw_pkg::CELLS - tcsw_pkg::COLUMNS) begin
          // Hand over to the fill at the first cell of the bottom row.
          fill_zero_d = 1'b0;
          state_d     = S_FILL;
        end else begin
          cnt_d = cnt_q + CellAw'(1);
        end
      end

      S_FILL: begin
        ram_wr.we   = 1'b1;
        ram_wr.addr = cnt_q;
        ram_wr.data = fill_zero_q ? tcsw_pkg::cell_t'('0) :
                      tcsw_pkg::cell_t'{color: color_q, chr: tcsw_pkg::SpaceCode};
        if (32'(cnt_q) == tcsw_pkg::CELLS - 1) begin
          priority if (fill_zero_q) begin
            state_d = S_IDLE;
          end else if (pend_q) begin
            state_d = S_WRITE;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          cnt_d = cnt_q + CellAw'(1);
        end
      end

      S_DONE: begin
        // Hold until the output register is free.
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      cnt_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      fill_zero_q <= 1'b1;
      pend_q      <= 1'b0;
      color_q     <= tcsw_pkg::ResetColor;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      row_q       <= row_d;
      col_q       <= col_d;
      fill_zero_q <= fill_zero_d;
      pend_q      <= pend_d;
      if (cfg_i.valid && cfg_i.ready) begin
        color_q <= cfg_i.text_color;
      end
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pend_char_q <= pend_char_d;
    cell_q      <= cell_d;
    if (rsp_load) begin
      rsp_row_q  <= row_q;
      rsp_col_q  <= col_q;
      rsp_cell_q <= cell_q;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.cursor_row_out = rsp_row_q;
  assign rsp_o.cursor_col_out = rsp_col_q;
  assign rsp_o.cell_char      = rsp_cell_q.chr;
  assign rsp_o.cell_color     = rsp_cell_q.color;

  `TCSW_ASSERT(a_cursor_bounds, clk_i, rst_ni,
               (32'(col_q) <= tcsw_pkg::COLUMNS) && (32'(row_q) < tcsw_pkg::ROWS))
  `TCSW_ASSERT(a_no_same_cell, clk_i, rst_ni,
               (ram_wr.we && ram_rd.re) |-> (ram_wr.addr != ram_rd.addr))
  `TCSW_ASSERT(a_rsp_from_done, clk_i, rst_ni, $rose(rsp_valid_q) |-> $past(state_q == S_DONE))
  `TCSW_ASSERT(a_write_in_store, clk_i, rst_ni, ram_wr.we |-> (32'(ram_wr.addr) < tcsw_pkg::CELLS))

endmodule

[hw/rtl/tcsw_screen_ram.sv]
`timescale 1ns / 1ps

module tcsw_screen_ram (
  input  logic              clk_i,
  input  tcsw_pkg::ram_wr_t wr_i,
  input  tcsw_pkg::ram_rd_t rd_i,
  output tcsw_pkg::cell_t   rdata_o
);

  tcsw_pkg::cell_t mem_q [tcsw_pkg::CELLS];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      rdata_o <= mem_q[rd_i.addr];
    end
  end

endmodule
